// File: rtl/ugns_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the uniform grid neighbor search block.
// No dependencies; every other file of the block imports this package.
package ugns_pkg;

  localparam int COORD_W  = 16;
  localparam int QUO_W    = COORD_W - 1;
  localparam int SIDE_W   = 15;
  localparam int NCELL_W  = 9;
  localparam int CELL_W   = 8;
  localparam int RANGE_W  = 16;
  localparam int SQ_W     = 2 * RANGE_W;
  localparam int IDX_IN_W = 6;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [NCELL_W-1:0] CELLS_MAX  = 9'd256;
  localparam logic [SIDE_W-1:0]  SIDE_RST   = 15'd64;
  localparam logic [NCELL_W-1:0] CELLS_RST  = 9'd16;

  localparam logic [1:0] REG_CELL_SIDE    = 2'd0;
  localparam logic [1:0] REG_CELLS_ACROSS = 2'd1;
  localparam logic [1:0] REG_CELLS_DOWN   = 2'd2;

  typedef struct packed {
    logic [SIDE_W-1:0]  side;
    logic [NCELL_W-1:0] nx;
    logic [NCELL_W-1:0] ny;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CELL_W-1:0]         cx;
    logic [CELL_W-1:0]         cy;
  } ent_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CELL_W-1:0]         cx;
    logic [CELL_W-1:0]         cy;
    logic [RANGE_W-1:0]        r;
    logic [SQ_W-1:0]           r2;
  } asker_t;

  typedef struct packed {
    logic                vld;
    logic [IDX_IN_W-1:0] idx;
  } tag_t;

endpackage

// File: rtl/ugns_cfg.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on ugns_pkg; delivers the grid setup with zero and oversize values folded.
module ugns_cfg import ugns_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic [SIDE_W-1:0]  side_r;
  logic [NCELL_W-1:0] across_r;
  logic [NCELL_W-1:0] down_r;
  logic               wr_en;
  logic [1:0]         reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= SIDE_RST;
      across_r <= CELLS_RST;
      down_r   <= CELLS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CELL_SIDE:    side_r   <= pwdata[SIDE_W-1:0];
        REG_CELLS_ACROSS: across_r <= pwdata[NCELL_W-1:0];
        REG_CELLS_DOWN:   down_r   <= pwdata[NCELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CELL_SIDE:    prdata = DATA_W'(side_r);
      REG_CELLS_ACROSS: prdata = DATA_W'(across_r);
      REG_CELLS_DOWN:   prdata = DATA_W'(down_r);
      default:          prdata = '0;
    endcase
  end

  function automatic logic [NCELL_W-1:0] fold_cells(input logic [NCELL_W-1:0] n);
    logic [NCELL_W-1:0] v;
    if (n == '0) v = NCELL_W'(1);
    else if (n > CELLS_MAX) v = CELLS_MAX;
    else v = n;
    return v;
  endfunction

  always_comb begin
    cfg.side = (side_r == '0) ? SIDE_W'(1) : side_r;
    cfg.nx   = fold_cells(across_r);
    cfg.ny   = fold_cells(down_r);
  end

endmodule

// File: rtl/ugns_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the cell index of one axis.
// Depends on ugns_pkg for the coordinate and cell side widths.
module ugns_div import ugns_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [QUO_W-1:0]  num,
  input  logic [SIDE_W-1:0] den,
  output logic [QUO_W-1:0]  quo,
  output logic              done
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SIDE_W-1:0] rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [SIDE_W-1:0] den_r;
  logic [SIDE_W:0]   trial;
  logic              ge;
  logic [SIDE_W-1:0] rem_nxt;

  assign trial   = {rem_r, quo_r[QUO_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? SIDE_W'(trial - {1'b0, den_r}) : SIDE_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[QUO_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// File: rtl/ugns_dist.sv
`timescale 1ns / 1ps
// Three-stage neighbor test on one table entry per advance: cell window and
// axis range, squares, then squared distance against the squared radius.
// Depends on ugns_pkg.
module ugns_dist import ugns_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  tag_t   tag,
  input  ent_t   ent,
  input  asker_t ask,
  input  cfg_t   cfg,
  output tag_t   hit
);

  logic [COORD_W:0]   dfx, dfy, adx, ady;
  logic               in_x, in_y, near_x, near_y;
  logic               s2_vld_r, s3_vld_r;
  logic [IDX_IN_W-1:0] s2_idx_r, s3_idx_r;
  logic [RANGE_W-1:0] s2_dx_r, s2_dy_r;
  logic [SQ_W-1:0]    s3_dx2_r, s3_dy2_r;
  logic [SQ_W:0]      sum;

  function automatic logic near_cell(input logic [CELL_W-1:0] c, input logic [CELL_W-1:0] ctr,
                                     input logic [NCELL_W-1:0] n);
    logic [NCELL_W:0] cw, tw;
    cw = (NCELL_W+1)'(c);
    tw = (NCELL_W+1)'(ctr);
    return (cw < {1'b0, n}) && (cw + 1'b1 >= tw) && (cw <= tw + 1'b1);
  endfunction

  always_comb begin
    dfx    = {ask.x[COORD_W-1], ask.x} - {ent.x[COORD_W-1], ent.x};
    dfy    = {ask.y[COORD_W-1], ask.y} - {ent.y[COORD_W-1], ent.y};
    adx    = dfx[COORD_W] ? ('0 - dfx) : dfx;
    ady    = dfy[COORD_W] ? ('0 - dfy) : dfy;
    in_x   = adx <= {1'b0, ask.r};
    in_y   = ady <= {1'b0, ask.r};
    near_x = near_cell(ent.cx, ask.cx, cfg.nx);
    near_y = near_cell(ent.cy, ask.cy, cfg.ny);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= tag.vld && near_x && near_y && in_x && in_y;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_idx_r <= tag.idx;
      s2_dx_r  <= adx[RANGE_W-1:0];
      s2_dy_r  <= ady[RANGE_W-1:0];
      s3_idx_r <= s2_idx_r;
      s3_dx2_r <= s2_dx_r * s2_dx_r;
      s3_dy2_r <= s2_dy_r * s2_dy_r;
    end
  end

  assign sum     = {1'b0, s3_dx2_r} + {1'b0, s3_dy2_r};
  assign hit.vld = s3_vld_r && (sum <= {1'b0, ask.r2});
  assign hit.idx = s3_idx_r;

endmodule

// File: rtl/uniform_grid_neighbour_search_top.sv
`timescale 1ns / 1ps
// Uniform grid neighbor search: a table of up to MAX_ENTITIES entities held in one
// single-port-read RAM with their positions and grid cells. Each input word either
// stores a new position (cmd 0) or only asks (cmd 1); the block answers with one word
// per neighbor in ascending slot order, last set on the final one, or one word with
// found clear. An item passes in order through the accept, an asker read for a query
// only, a divider start, the per-axis cell dividers, one RAM read per table entry in
// the scan, the drain of the distance pipeline and the final word. A query for an
// unplaced slot or an item for an out-of-range slot goes straight to the final word.
// Result stalls hold the scan. Depends on ugns_pkg, ugns_cfg, ugns_div and ugns_dist.
module uniform_grid_neighbour_search_top import ugns_pkg::*; #(
  parameter int MAX_ENTITIES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [IDX_IN_W-1:0]        in_entity_index,
  input  logic signed [COORD_W-1:0]  in_pos_x,
  input  logic signed [COORD_W-1:0]  in_pos_y,
  input  logic [RANGE_W-1:0]         in_sense_range,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [IDX_IN_W-1:0]        out_neighbour_index,
  output logic                       out_found,
  output logic                       out_last,
  output logic                       out_status,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int IDX_W = $clog2(MAX_ENTITIES);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_ENTITIES - 1);
  localparam logic [IDX_IN_W:0] ENT_LIMIT = (IDX_IN_W+1)'(MAX_ENTITIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDASK = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;

  localparam logic CMD_STORE = 1'b0;

  cfg_t cfg;
  logic [2:0] state_r, state_nxt;

  logic                      cmd_r, bad_r;
  logic [IDX_W-1:0]          who_r, scan_idx_r, pend_idx_r;
  logic [RANGE_W-1:0]        r_r;
  logic [SQ_W-1:0]           r2_r;
  logic signed [COORD_W-1:0] ask_x_r, ask_y_r;
  logic [CELL_W-1:0]         ask_cx_r, ask_cy_r;
  logic [1:0]                drain_r;
  logic                      pend_vld_r;
  logic [MAX_ENTITIES-1:0]   placed_r;

  logic                      out_valid_r, out_found_r, out_last_r, out_status_r;
  logic [IDX_IN_W-1:0]       out_idx_r;

  ent_t                      mem [MAX_ENTITIES];
  ent_t                      rd_data_r;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;

  logic                      in_acc, in_range, adv, pipe_adv, div_start;
  logic [IDX_W-1:0]          idx_in;
  logic [QUO_W-1:0]          quo_x, quo_y;
  logic                      div_done, div_done_y;
  logic [CELL_W-1:0]         cx_calc, cy_calc;
  tag_t                      tag_issue, tag1_r, hit;
  asker_t                    ask;

  logic                      push;
  logic [IDX_IN_W-1:0]       push_idx;
  logic                      push_found, push_last, push_status;

  ugns_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  ugns_div u_div_x (
    .clk, .rst_n, .start(div_start), .num(ask_x_r[QUO_W-1:0]), .den(cfg.side),
    .quo(quo_x), .done(div_done)
  );

  ugns_div u_div_y (
    .clk, .rst_n, .start(div_start), .num(ask_y_r[QUO_W-1:0]), .den(cfg.side),
    .quo(quo_y), .done(div_done_y)
  );

  ugns_dist u_dist (
    .clk, .rst_n, .adv(pipe_adv), .tag(tag1_r), .ent(rd_data_r), .ask, .cfg, .hit
  );

  assign pready    = 1'b1;
  assign in_stall  = state_r != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign in_range  = {1'b0, in_entity_index} < ENT_LIMIT;
  assign idx_in    = in_entity_index[IDX_W-1:0];
  assign adv       = !out_valid_r || !out_stall;
  assign pipe_adv  = adv && (state_r == S_SCAN || state_r == S_DRAIN);
  assign div_start = state_r == S_START;

  function automatic logic [CELL_W-1:0] clamp_cell(input logic neg, input logic [QUO_W-1:0] q,
                                                  input logic [NCELL_W-1:0] n);
    logic [QUO_W-1:0] top;
    logic [QUO_W-1:0] v;
    top = QUO_W'(n - NCELL_W'(1));
    if (neg) v = '0;
    else if (q > top) v = top;
    else v = q;
    return v[CELL_W-1:0];
  endfunction

  assign cx_calc = clamp_cell(ask_x_r[COORD_W-1], quo_x, cfg.nx);
  assign cy_calc = clamp_cell(ask_y_r[COORD_W-1], quo_y, cfg.ny);

  always_comb begin
    ask.x  = ask_x_r;
    ask.y  = ask_y_r;
    ask.cx = ask_cx_r;
    ask.cy = ask_cy_r;
    ask.r  = r_r;
    ask.r2 = r2_r;
  end

  // read port: asker fetch on accept, one table entry per advance while scanning
  assign rd_en   = (in_acc && in_range && in_cmd != CMD_STORE) || (state_r == S_SCAN && adv);
  assign rd_addr = (state_r == S_IDLE) ? idx_in : scan_idx_r;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
    if (state_r == S_DIV && div_done && div_done_y && cmd_r == CMD_STORE) begin
      mem[who_r] <= '{x: ask_x_r, y: ask_y_r, cx: cx_calc, cy: cy_calc};
    end
  end

  assign tag_issue.vld = (state_r == S_SCAN) && (scan_idx_r != who_r) && placed_r[scan_idx_r];
  assign tag_issue.idx = IDX_IN_W'(scan_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) tag1_r.vld <= 1'b0;
    else if (pipe_adv) tag1_r.vld <= tag_issue.vld;
    if (pipe_adv) tag1_r.idx <= tag_issue.idx;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_range) state_nxt = S_FINAL;
          else if (in_cmd == CMD_STORE) state_nxt = S_START;
          else if (placed_r[idx_in]) state_nxt = S_RDASK;
          else state_nxt = S_FINAL;
        end
      end
      S_RDASK: state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_done && div_done_y) state_nxt = S_SCAN;
      S_SCAN:  if (adv && scan_idx_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: if (adv && drain_r == 2'd2) state_nxt = S_FINAL;
      S_FINAL: if (adv) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      placed_r   <= '0;
      pend_vld_r <= 1'b0;
      bad_r      <= 1'b0;
      drain_r    <= '0;
      scan_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pend_vld_r <= 1'b0;
            bad_r      <= !in_range || (in_cmd != CMD_STORE && !placed_r[idx_in]);
          end
        end
        S_DIV: begin
          if (div_done && div_done_y) begin
            scan_idx_r <= '0;
            if (cmd_r == CMD_STORE) placed_r[who_r] <= 1'b1;
          end
        end
        S_SCAN: begin
          if (adv) begin
            drain_r <= '0;
            if (scan_idx_r != LAST_IDX) scan_idx_r <= scan_idx_r + IDX_W'(1);
          end
        end
        S_DRAIN: if (adv) drain_r <= drain_r + 2'd1;
        default: ;
      endcase
      if (pipe_adv && hit.vld) pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_cmd;
      who_r   <= idx_in;
      r_r     <= in_sense_range;
      ask_x_r <= in_pos_x;
      ask_y_r <= in_pos_y;
    end
    if (state_r == S_RDASK) begin
      ask_x_r <= rd_data_r.x;
      ask_y_r <= rd_data_r.y;
    end
    if (state_r == S_START) r2_r <= r_r * r_r;
    if (state_r == S_DIV && div_done && div_done_y) begin
      ask_cx_r <= cx_calc;
      ask_cy_r <= cy_calc;
    end
    if (pipe_adv && hit.vld) pend_idx_r <= hit.idx[IDX_W-1:0];
  end

  // a held hit goes out when the next one arrives; the final word closes the item
  always_comb begin
    push        = 1'b0;
    push_idx    = IDX_IN_W'(pend_idx_r);
    push_found  = 1'b1;
    push_last   = 1'b0;
    push_status = 1'b0;
    if (pipe_adv && hit.vld && pend_vld_r) begin
      push = 1'b1;
    end else if (state_r == S_FINAL && adv) begin
      push      = 1'b1;
      push_last = 1'b1;
      if (!pend_vld_r) begin
        push_idx    = '0;
        push_found  = 1'b0;
        push_status = bad_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (push) begin
      out_idx_r    <= push_idx;
      out_found_r  <= push_found;
      out_last_r   <= push_last;
      out_status_r <= push_status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_neighbour_index = out_idx_r;
  assign out_found           = out_found_r;
  assign out_last            = out_last_r;
  assign out_status          = out_status_r;

endmodule

// File: rtl/ugns_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the neighbor search top level, attached by bind.
// Depends on ugns_pkg for field widths.
module ugns_chk import ugns_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [IDX_IN_W-1:0] out_neighbour_index,
  input logic                out_found,
  input logic                out_last,
  input logic                out_status
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neighbour_index) &&
      $stable(out_found) && $stable(out_last) && $stable(out_status))
    else $error("stalled result word changed");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("word without a neighbor is not last");

  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_found && out_neighbour_index == '0)
    else $error("unplaced-asker word names a neighbor");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the item was answered");

endmodule

bind uniform_grid_neighbour_search_top ugns_chk u_chk (.*);
